>>> sv/dcse_pkg.sv
`default_nettype none
package dcse_pkg;

    localparam int MaxRes = 10;

    typedef logic [3:0] t_res_cnt;

    typedef enum logic [1:0] {
        CMD_START     = 2'd0,
        CMD_CELL      = 2'd1,
        CMD_END       = 2'd2,
        CMD_NEW_BLOCK = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_CODE   = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_OFFSET = 2'd2,
        KIND_REPORT = 2'd3
    } t_kind;

    localparam logic [7:0] OP_MOV_SI = 8'hBE;
    localparam logic [7:0] OP_MOV_DI = 8'hBF;
    localparam logic [7:0] OP_MOVSW  = 8'hA5;
    localparam logic [7:0] OP_MOV_CX = 8'hB9;
    localparam logic [7:0] OP_REP    = 8'hF3;
    localparam logic [7:0] OP_RETF   = 8'hCB;

    localparam logic [15:0] LimitReset = 16'd32768;
    localparam logic        REG_BLOCK_LIMIT = 1'b0;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic        overflow;
    } t_result;

    typedef struct packed {
        t_res_cnt                  count;
        t_result [MaxRes-1:0]      entries;
    } t_batch;

    function automatic t_result code_ent(input logic [7:0] b);
        t_result r;
        r.kind     = KIND_CODE;
        r.value    = {8'h00, b};
        r.overflow = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [3:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {13'd0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage
`default_nettype wire

>>> sv/dcse_item_if.sv
`default_nettype none
interface dcse_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [11:0] cell_index;
    logic [15:0] char_code;

    modport source (output valid, output cmd, output cell_index, output char_code,
                    input ready);
    modport sink   (input valid, input cmd, input cell_index, input char_code,
                    output ready);
endinterface
`default_nettype wire

>>> sv/dcse_result_if.sv
`default_nettype none
interface dcse_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] value;
    logic        overflow;
    logic        last;

    modport source (output valid, output kind, output value, output overflow,
                    output last, input ready);
    modport sink   (input valid, input kind, input value, input overflow,
                    input last, output ready);
endinterface
`default_nettype wire

>>> sv/dcse_apb_regs.sv
`default_nettype none
module dcse_apb_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    output logic [15:0]      o_block_limit
);
    import dcse_pkg::*;

    logic [15:0] r_limit;
    logic        wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_BLOCK_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (wr_en) begin
            r_limit <= i_pwdata[15:0];
        end
    end

    assign o_prdata      = (i_paddr[2] == REG_BLOCK_LIMIT) ? {16'd0, r_limit} : 32'd0;
    assign o_block_limit = r_limit;

    logic unused_addr;
    assign unused_addr = ^{i_paddr[1:0], i_pwdata[31:16]};
endmodule
`default_nettype wire

>>> sv/dcse_expand.sv
`default_nettype none
module dcse_expand #(
    parameter int unsigned CELL_COUNT = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    dcse_item_if.sink              i_item,
    input  wire logic [15:0]       i_block_limit,
    input  wire logic              i_can_load,
    output logic                   o_load,
    output dcse_pkg::t_batch       o_batch
);
    import dcse_pkg::*;

    logic        r_in_valid;
    t_cmd        r_cmd;
    logic [11:0] r_cell;
    logic [15:0] r_char;

    logic        r_run_open,  n_run_open;
    logic [11:0] r_first,     n_first;
    logic [11:0] r_last,      n_last;
    logic [12:0] r_len,       n_len;
    logic [15:0] r_dwc,       n_dwc;
    logic [15:0] r_cbc,       n_cbc;
    logic [15:0] r_sc,        n_sc;

    logic                 take;
    t_result [MaxRes-1:0] ent;
    t_res_cnt             close_cnt;
    t_res_cnt             pos;
    t_res_cnt             n_bytes;
    t_res_cnt             cnt;
    logic                 in_range;
    logic                 adjacent;
    logic [15:0]          di;
    logic [15:0]          si;
    logic [18:0]          size;
    t_result              report;

    assign take          = r_in_valid && i_can_load;
    assign i_item.ready  = !r_in_valid || i_can_load;
    assign o_load        = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_cmd  <= t_cmd'(i_item.cmd);
            r_cell <= i_item.cell_index;
            r_char <= i_item.char_code;
        end
    end

    always_comb begin
        ent       = '0;
        in_range  = 32'(r_cell) < CELL_COUNT;
        adjacent  = r_run_open && ({1'b0, r_cell} == ({1'b0, r_last} + 13'd1));
        di        = {3'b000, r_first, 1'b0};
        si        = r_dwc[15] ? 16'hFFFF : {r_dwc[14:0], 1'b0};
        close_cnt = (r_len <= 13'd3) ? t_res_cnt'(4'd3 + {2'b00, r_len[1:0]}) : t_res_cnt'(8);

        ent[0] = code_ent(OP_MOV_DI);
        ent[1] = code_ent(di[7:0]);
        ent[2] = code_ent(di[15:8]);
        if (r_len <= 13'd3) begin
            for (int k = 0; k < 3; k++) begin
                if (13'(k) < r_len) begin
                    ent[3+k] = code_ent(OP_MOVSW);
                end
            end
        end else begin
            ent[3] = code_ent(OP_MOV_CX);
            ent[4] = code_ent(r_len[7:0]);
            ent[5] = code_ent({3'b000, r_len[12:8]});
            ent[6] = code_ent(OP_REP);
            ent[7] = code_ent(OP_MOVSW);
        end

        n_run_open = r_run_open;
        n_first    = r_first;
        n_last     = r_last;
        n_len      = r_len;
        n_dwc      = r_dwc;
        n_sc       = r_sc;
        n_bytes    = '0;
        cnt        = '0;
        pos        = '0;
        size       = '0;
        report     = '0;

        case (r_cmd)
            CMD_START: begin
                ent[0].kind     = KIND_OFFSET;
                ent[0].value    = r_cbc;
                ent[0].overflow = 1'b0;
                ent[1]          = code_ent(OP_MOV_SI);
                ent[2]          = code_ent(si[7:0]);
                ent[3]          = code_ent(si[15:8]);
                cnt             = t_res_cnt'(4);
                n_bytes         = t_res_cnt'(3);
                n_run_open      = 1'b0;
                n_len           = '0;
                n_sc            = sat_add16(r_sc, 4'd1);
            end
            CMD_CELL: begin
                if (in_range) begin
                    pos = (r_run_open && !adjacent) ? close_cnt : '0;
                    ent[pos].kind     = KIND_DATA;
                    ent[pos].value    = r_char;
                    ent[pos].overflow = 1'b0;
                    cnt     = pos + t_res_cnt'(1);
                    n_bytes = pos;
                    n_dwc   = sat_add16(r_dwc, 4'd1);
                    if (adjacent) begin
                        n_last = r_cell;
                        n_len  = r_len + 13'd1;
                    end else begin
                        n_run_open = 1'b1;
                        n_first    = r_cell;
                        n_last     = r_cell;
                        n_len      = 13'd1;
                    end
                end
            end
            CMD_END: begin
                pos        = r_run_open ? close_cnt : '0;
                ent[pos]   = code_ent(OP_RETF);
                n_bytes    = pos + t_res_cnt'(1);
                cnt        = pos + t_res_cnt'(2);
                n_run_open = 1'b0;
                n_len      = '0;
            end
            CMD_NEW_BLOCK: begin
                n_run_open = 1'b0;
                n_first    = '0;
                n_last     = '0;
                n_len      = '0;
                n_dwc      = '0;
                n_sc       = '0;
            end
            default: begin
                cnt = '0;
            end
        endcase

        n_cbc = (r_cmd == CMD_NEW_BLOCK) ? 16'd0 : sat_add16(r_cbc, n_bytes);
        size  = {2'b00, r_dwc, 1'b0} + {3'b000, n_cbc} + {2'b00, r_sc, 1'b0} + 19'd2;
        report.kind     = KIND_REPORT;
        report.value    = (size > 19'h0FFFF) ? 16'hFFFF : size[15:0];
        report.overflow = size > {3'b000, i_block_limit};
        if (r_cmd == CMD_END) begin
            ent[pos + t_res_cnt'(1)] = report;
        end

        o_batch.count   = cnt;
        o_batch.entries = ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
            r_first    <= '0;
            r_last     <= '0;
            r_len      <= '0;
            r_dwc      <= '0;
            r_cbc      <= '0;
            r_sc       <= '0;
        end else if (take) begin
            r_run_open <= n_run_open;
            r_first    <= n_first;
            r_last     <= n_last;
            r_len      <= n_len;
            r_dwc      <= n_dwc;
            r_cbc      <= n_cbc;
            r_sc       <= n_sc;
        end
    end
endmodule
`default_nettype wire

>>> sv/dcse_drain.sv
`default_nettype none
module dcse_drain (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire dcse_pkg::t_batch  i_batch,
    output logic                   o_can_load,
    dcse_result_if.source          o_result
);
    import dcse_pkg::*;

    t_result [MaxRes-1:0] r_buf;
    t_res_cnt             r_num;
    t_res_cnt             r_idx;
    logic                 is_last;
    logic                 xfer;
    t_result              cur;

    assign is_last    = (r_idx + t_res_cnt'(1)) == r_num;
    assign xfer       = o_result.valid && o_result.ready;
    assign o_can_load = !o_result.valid || (o_result.ready && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_num <= i_batch.count;
            r_idx <= '0;
        end else if (xfer) begin
            r_idx <= r_idx + t_res_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_batch.entries;
        end
    end

    assign cur               = r_buf[r_idx];
    assign o_result.valid    = r_idx != r_num;
    assign o_result.kind     = cur.kind;
    assign o_result.value    = cur.value;
    assign o_result.overflow = cur.overflow;
    assign o_result.last     = is_last;
endmodule
`default_nettype wire

>>> sv/dirty_cell_span_code_emitter_top.sv
// Channel   Dir  Modport  Payload
// i_item    in   sink     cmd[1:0], cell_index[11:0], char_code[15:0]
// o_result  out  source   kind[1:0], value[15:0], overflow, last
// apb       in   slave    psel/penable/pwrite/paddr[2:0]/pwdata -> prdata, pready
//
// An item waits in the input register, then its results (0 to 10) load into the
// result buffer and leave one per cycle while o_result is ready. The single result
// port sets the rate: an adjacent cell gives one result, a cell that closes a run up
// to nine. The next item is taken while results still drain.
// Reset is synchronous, active low; a stall on o_result holds the buffer and the input.
`default_nettype none
module dirty_cell_span_code_emitter_top #(
    parameter int unsigned CELL_COUNT = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dcse_item_if.sink        i_item,
    dcse_result_if.source    o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dcse_pkg::*;

    logic [15:0] block_limit;
    logic        can_load;
    logic        load;
    t_batch      batch;

    dcse_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_prdata      (prdata),
        .o_pready      (pready),
        .o_block_limit (block_limit)
    );

    dcse_expand #(
        .CELL_COUNT (CELL_COUNT)
    ) u_expand (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_block_limit (block_limit),
        .i_can_load    (can_load),
        .o_load        (load),
        .o_batch       (batch)
    );

    dcse_drain u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_result   (o_result)
    );
endmodule
`default_nettype wire

>>> dv/dirty_cell_span_code_emitter_top_tb.sv
module dirty_cell_span_code_emitter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcse_pkg::*;

    localparam int CellCount = 4096;
    localparam int WatchdogLimit = 2000;
    localparam int HoldCycles = 300;
    localparam int SettleCycles = 16;
    localparam int PhaseItems = 8;
    localparam int LongRunCells = 260;
    localparam logic [2:0] LimitAddr = {REG_BLOCK_LIMIT, 2'b00};

    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SENDER_GAPS,
        TRAFFIC_RECEIVER_STALLS,
        TRAFFIC_BOTH
    } t_traffic;

    typedef struct {
        t_cmd        cmd;
        logic [11:0] cell_idx;
        logic [15:0] ch;
    } t_screen_item;

    typedef struct {
        t_kind       kind;
        logic [15:0] value;
        logic        overflow;
        logic        last;
    } t_emission;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dcse_item_if   item_bus ();
    dcse_result_if result_bus ();

    dirty_cell_span_code_emitter_top #(
        .CELL_COUNT(CellCount)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_result(result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_screen_item pending_updates[$];
    t_emission    expected_emissions[$];
    t_emission    item_emissions[$];

    int mismatches = 0;
    int cfg_errors = 0;
    int items_queued = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_requests = 0;
    int hold_served;
    int hold_left;
    int quiet_cycles;

    logic        span_open = 1'b0;
    logic [11:0] span_first = '0;
    logic [11:0] span_last = '0;
    logic [12:0] span_len = '0;
    logic [15:0] data_words = '0;
    logic [15:0] code_bytes = '0;
    logic [15:0] streams = '0;
    logic [15:0] limit_bytes;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [15:0] sat_inc(input logic [15:0] a);
        return (a == 16'hFFFF) ? a : a + 16'd1;
    endfunction

    function automatic void add_emission(input t_kind kind, input logic [15:0] value,
                                         input logic overflow);
        t_emission e;
        e.kind     = kind;
        e.value    = value;
        e.overflow = overflow;
        e.last     = 1'b0;
        item_emissions.insert(item_emissions.size(), e);
    endfunction

    function automatic void add_code(input logic [7:0] b);
        add_emission(KIND_CODE, {8'h00, b}, 1'b0);
        code_bytes = sat_inc(code_bytes);
    endfunction

    function automatic void close_span();
        logic [15:0] di;
        int k;
        if (!span_open) begin
            return;
        end
        di = {3'b000, span_first, 1'b0};
        add_code(OP_MOV_DI);
        add_code(di[7:0]);
        add_code(di[15:8]);
        if (span_len <= 13'd3) begin
            for (k = 0; k < span_len; k++) begin
                add_code(OP_MOVSW);
            end
        end else begin
            add_code(OP_MOV_CX);
            add_code(span_len[7:0]);
            add_code({3'b000, span_len[12:8]});
            add_code(OP_REP);
            add_code(OP_MOVSW);
        end
        span_open = 1'b0;
        span_len  = '0;
    endfunction

    function automatic void predict_item(input t_cmd cmd, input logic [11:0] cell_idx,
                                         input logic [15:0] ch);
        logic [16:0] si;
        logic [31:0] total;
        item_emissions.delete();
        case (cmd)
            CMD_START: begin
                si = {data_words, 1'b0};
                if (si[16]) begin
                    si = 17'h0FFFF;
                end
                span_open = 1'b0;
                span_len  = '0;
                add_emission(KIND_OFFSET, code_bytes, 1'b0);
                streams = sat_inc(streams);
                add_code(OP_MOV_SI);
                add_code(si[7:0]);
                add_code(si[15:8]);
            end
            CMD_CELL: begin
                if (cell_idx < CellCount) begin
                    if (span_open && ({1'b0, cell_idx} == {1'b0, span_last} + 13'd1)) begin
                        span_last = cell_idx;
                        span_len  = span_len + 13'd1;
                    end else begin
                        close_span();
                        span_open  = 1'b1;
                        span_first = cell_idx;
                        span_last  = cell_idx;
                        span_len   = 13'd1;
                    end
                    add_emission(KIND_DATA, ch, 1'b0);
                    data_words = sat_inc(data_words);
                end
            end
            CMD_END: begin
                close_span();
                add_code(OP_RETF);
                total = {15'd0, data_words, 1'b0} + {16'd0, code_bytes}
                      + {15'd0, streams, 1'b0} + 32'd2;
                add_emission(KIND_REPORT, (total > 32'h0000FFFF) ? 16'hFFFF : total[15:0],
                             total > {16'd0, limit_bytes});
            end
            default: begin
                span_open  = 1'b0;
                span_first = '0;
                span_last  = '0;
                span_len   = '0;
                data_words = '0;
                code_bytes = '0;
                streams    = '0;
            end
        endcase
        if (item_emissions.size() != 0) begin
            item_emissions[item_emissions.size() - 1].last = 1'b1;
        end
        foreach (item_emissions[i]) begin
            expected_emissions.insert(expected_emissions.size(), item_emissions[i]);
        end
    endfunction

    always @(posedge i_clk) begin : feed_items
        t_screen_item head;
        if (!i_rst_n) begin
            item_bus.valid      <= 1'b0;
            item_bus.cmd        <= CMD_START;
            item_bus.cell_index <= '0;
            item_bus.char_code  <= '0;
        end else if (!item_bus.valid || item_bus.ready) begin
            if (pending_updates.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                head = pending_updates.pop_front();
                item_bus.valid      <= 1'b1;
                item_bus.cmd        <= head.cmd;
                item_bus.cell_index <= head.cell_idx;
                item_bus.char_code  <= head.ch;
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && item_bus.valid && item_bus.ready) begin
            predict_item(t_cmd'(item_bus.cmd), item_bus.cell_index, item_bus.char_code);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            hold_served      <= 0;
            hold_left        <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served      <= hold_requests;
            hold_left        <= HoldCycles;
            result_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left        <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_emission want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (expected_emissions.size() == 0) begin
                $error("unexpected result transfer: kind %0d value %h overflow %b last %b",
                       result_bus.kind, result_bus.value, result_bus.overflow,
                       result_bus.last);
                mismatches++;
            end else begin
                want = expected_emissions.pop_front();
                if (result_bus.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, result_bus.kind);
                    mismatches++;
                end
                if (result_bus.value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, result_bus.value);
                    mismatches++;
                end
                if (result_bus.overflow !== want.overflow) begin
                    $error("overflow: expected %b, got %b", want.overflow,
                           result_bus.overflow);
                    mismatches++;
                end
                if (result_bus.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, result_bus.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (item_bus.valid && item_bus.ready)
                || (result_bus.valid && result_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("[dirty_cell_span_code_emitter_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void queue_item(input t_cmd cmd, input logic [11:0] cell_idx,
                                       input logic [15:0] ch);
        t_screen_item it;
        it.cmd      = cmd;
        it.cell_idx = cell_idx;
        it.ch       = ch;
        pending_updates.insert(pending_updates.size(), it);
        items_queued++;
    endfunction

    function automatic void queue_frame(input int n_cells);
        int next_idx;
        int k;
        int r;
        if ($urandom_range(9) == 0) begin
            queue_item(CMD_NEW_BLOCK, 12'($urandom), 16'($urandom));
        end
        queue_item(CMD_START, 12'($urandom), 16'($urandom));
        next_idx = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(600);
        for (k = 0; k < n_cells; k++) begin
            queue_item(CMD_CELL, next_idx[11:0], 16'($urandom));
            r = $urandom_range(99);
            if (r < 55) begin
                next_idx = next_idx + 1;
            end else if (r < 85) begin
                next_idx = next_idx + $urandom_range(2, 40);
            end else if (r < 94) begin
                next_idx = $urandom_range(4095);
            end else begin
                queue_item(t_cmd'($urandom_range(3)), 12'($urandom), 16'($urandom));
            end
            if (next_idx > 4095) begin
                next_idx = $urandom_range(63);
            end
        end
        if ($urandom_range(9) != 0) begin
            queue_item(CMD_END, 12'($urandom), 16'($urandom));
        end
    endfunction

    function automatic void set_traffic(input t_traffic mode);
        case (mode)
            TRAFFIC_SENDER_GAPS: begin
                sender_idle_pct    = 69;
                receiver_stall_pct = 0;
            end
            TRAFFIC_RECEIVER_STALLS: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 69;
            end
            TRAFFIC_BOTH: begin
                sender_idle_pct    = 16;
                receiver_stall_pct = 16;
            end
            default: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_updates.size() != 0 || item_bus.valid
                || expected_emissions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic program_limit(input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LimitAddr;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_bytes = value;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== {16'h0000, value}) begin
            $error("block_limit_bytes: expected %h, got %h", {16'h0000, value}, prdata);
            cfg_errors++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int p;
        int k;
        int base;
        int phase_start;
        logic [15:0] lim;

        i_rst_n     = 1'b0;
        limit_bytes = LimitReset;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_traffic(TRAFFIC_STEADY);
        queue_item(CMD_START,     12'h000, 16'h0000);
        queue_item(CMD_CELL,      12'h000, 16'h0000);
        queue_item(CMD_CELL,      12'h001, 16'hFFFF);
        queue_item(CMD_CELL,      12'h002, 16'hA5A5);
        queue_item(CMD_CELL,      12'h00A, 16'h5A5A);
        queue_item(CMD_CELL,      12'hFFF, 16'hFFFF);
        queue_item(CMD_CELL,      12'h000, 16'h1234);
        queue_item(CMD_CELL,      12'h001, 16'h8001);
        queue_item(CMD_CELL,      12'h002, 16'h7FFE);
        queue_item(CMD_CELL,      12'h003, 16'h00FF);
        queue_item(CMD_CELL,      12'h005, 16'hFF00);
        queue_item(CMD_START,     12'hFFF, 16'hFFFF);
        queue_item(CMD_CELL,      12'h0C8, 16'h0F0F);
        queue_item(CMD_CELL,      12'h0C9, 16'hF0F0);
        queue_item(CMD_END,       12'hFFF, 16'hFFFF);
        queue_item(CMD_END,       12'h000, 16'h0000);
        queue_item(CMD_NEW_BLOCK, 12'hFFF, 16'hFFFF);
        queue_item(CMD_END,       12'h000, 16'h0000);
        queue_item(CMD_START,     12'h000, 16'h0000);
        queue_item(CMD_CELL,      12'h7FF, 16'h8000);
        queue_item(CMD_CELL,      12'h800, 16'h7FFF);
        queue_item(CMD_END,       12'h000, 16'h0000);
        wait_drained();

        for (p = 0; p < 8; p++) begin
            case (p)
                0:       lim = 16'd1;
                1:       lim = 16'd0;
                2:       lim = 16'hFFFF;
                3:       lim = 16'($urandom_range(20, 600));
                4:       lim = LimitReset;
                5:       lim = 16'($urandom_range(1, 100));
                6:       lim = 16'($urandom_range(100, 2000));
                default: lim = 16'($urandom);
            endcase
            program_limit(lim);
            set_traffic(t_traffic'(p % 4));
            if (p == 2) begin
                base = $urandom_range(0, 4095 - LongRunCells);
                queue_item(CMD_START, 12'($urandom), 16'($urandom));
                for (k = 0; k < LongRunCells; k++) begin
                    queue_item(CMD_CELL, 12'(base + k), 16'($urandom));
                end
                queue_item(CMD_END, 12'($urandom), 16'($urandom));
            end
            phase_start = items_queued;
            while (items_queued - phase_start < PhaseItems) begin
                queue_frame($urandom_range(1, 12));
            end
            if (p == 4) begin
                @(negedge i_clk);
                hold_requests++;
            end
            wait_drained();
        end

        if (mismatches == 0 && cfg_errors == 0) begin
            $display("[dirty_cell_span_code_emitter_top] OK");
        end else begin
            $display("[dirty_cell_span_code_emitter_top] ERROR");
        end
        $finish;
    end

endmodule
